// ----- rtl/core/xfcr_pkg.sv -----
// Shared constants, result type and action codes for the framed command receiver.
package xfcr_pkg;

  // Frame buffer size in bytes (head included); valid range 8 to 255
  localparam int unsigned BUFFER_BYTES = 128;
  localparam int unsigned CNT_W        = 8;

  localparam logic [CNT_W-1:0] BufferLimit = CNT_W'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] MinHeld     = CNT_W'(5);

  // Framing bytes
  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'hBB;

  // Command opcodes
  localparam logic [7:0] OP_START = 8'h01;
  localparam logic [7:0] OP_STOP  = 8'h02;
  localparam logic [7:0] OP_RESET = 8'h03;
  localparam logic [7:0] OP_QUERY = 8'h04;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_RESET   = 3'd3,
    ACT_QUERY   = 3'd4,
    ACT_UNKNOWN = 3'd5
  } action_e;

  typedef struct packed {
    logic       frame_end;
    logic       frame_ok;
    logic       overflow;
    logic [7:0] command_code;
    action_e    action;
    logic       slam_active;
  } result_t;

endpackage

// ----- rtl/core/xor_frame_command_receiver.sv -----
// Top level: hunts head/tail framed command requests and checks their XOR byte.
// A result is registered in the output buffer when its byte is accepted.
// Throughput: one byte per cycle while the output buffer is not full; a two-entry
// output buffer keeps input ready while one finished result waits downstream.
// Reset: frame state, running flag and output buffer clear asynchronously.
module xor_frame_command_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       frame_end_o,
  output logic       frame_ok_o,
  output logic       overflow_o,
  output logic [7:0] command_code_o,
  output logic [2:0] action_o,
  output logic       slam_active_o
);
  import xfcr_pkg::*;

  logic             in_frame_q, in_frame_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       len_q, len_d, len_eff;
  logic [7:0]       xor_q, xor_d;
  logic             captured_q, captured_d;
  logic             match_q, match_d;
  logic             run_q, run_d;
  logic [8:0]       pos_x;
  logic             accept;
  result_t          res;
  result_t          out_res;

  assign accept   = in_valid_i && in_ready_o;
  assign pos_x    = {1'b0, cnt_q};
  assign cnt_next = cnt_q + CNT_W'(1);
  assign len_eff  = (cnt_q == CNT_W'(2)) ? rx_byte_i : len_q;

  // Advance the frame parser by one byte
  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    xor_d      = xor_q;
    captured_d = captured_q;
    match_d    = match_q;
    run_d      = run_q;
    res        = '0;
    res.action = ACT_NONE;
    if (!in_frame_q) begin
      if (rx_byte_i == HEAD_BYTE) begin
        in_frame_d = 1'b1;
        cnt_d      = CNT_W'(1);
        cmd_d      = '0;
        len_d      = '0;
        xor_d      = '0;
        captured_d = 1'b0;
        match_d    = 1'b0;
      end
    end else begin
      cnt_d = cnt_next;
      if (cnt_q == CNT_W'(1)) cmd_d = rx_byte_i;
      if (cnt_q == CNT_W'(2)) len_d = rx_byte_i;
      // Fold command, length and data into the running XOR
      if (pos_x <= 9'd2 + {1'b0, len_eff}) xor_d = xor_q ^ rx_byte_i;
      // Capture the check byte and compare it against the XOR so far
      if (pos_x == 9'd3 + {1'b0, len_eff}) begin
        captured_d = 1'b1;
        match_d    = (xor_q == rx_byte_i);
      end
      if (cnt_next >= BufferLimit) begin
        in_frame_d    = 1'b0;
        res.frame_end = 1'b1;
        res.overflow  = 1'b1;
      end else if (rx_byte_i == TAIL_BYTE && cnt_next >= MinHeld) begin
        in_frame_d    = 1'b0;
        res.frame_end = 1'b1;
        // Early tail leaves captured_q low, so the frame is rejected
        if (captured_q && match_q) begin
          res.frame_ok     = 1'b1;
          res.command_code = cmd_q;
          case (cmd_q)
            OP_START: begin
              res.action = ACT_START;
              run_d      = 1'b1;
            end
            OP_STOP: begin
              res.action = ACT_STOP;
              run_d      = 1'b0;
            end
            OP_RESET: begin
              res.action = ACT_RESET;
              run_d      = 1'b0;
            end
            OP_QUERY: res.action = ACT_QUERY;
            default:  res.action = ACT_UNKNOWN;
          endcase
        end
      end
    end
    res.slam_active = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      cmd_q      <= '0;
      len_q      <= '0;
      xor_q      <= '0;
      captured_q <= 1'b0;
      match_q    <= 1'b0;
      run_q      <= 1'b0;
    end else if (accept) begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      cmd_q      <= cmd_d;
      len_q      <= len_d;
      xor_q      <= xor_d;
      captured_q <= captured_d;
      match_q    <= match_d;
      run_q      <= run_d;
    end
  end

  // Hold results until taken
  xfcr_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign frame_end_o    = out_res.frame_end;
  assign frame_ok_o     = out_res.frame_ok;
  assign overflow_o     = out_res.overflow;
  assign command_code_o = out_res.command_code;
  assign action_o       = out_res.action;
  assign slam_active_o  = out_res.slam_active;

`ifndef ASSERT_OFF
  a_ovf_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> frame_end_o && !frame_ok_o)
    else $error("overflow result not a rejected frame end");

  a_action_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_res.action != ACT_NONE) == frame_ok_o))
    else $error("action code disagrees with frame_ok");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (cnt_q != '0) && (cnt_q < BufferLimit))
    else $error("byte count out of range inside a frame");

  a_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_frame_q && rx_byte_i != HEAD_BYTE |=> !in_frame_q)
    else $error("frame opened without head byte");

  a_start_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.action == ACT_START |=> run_q)
    else $error("start command did not set running flag");
`endif

endmodule

// ----- rtl/core/xfcr_skid.sv -----
// Two-entry output buffer: result register plus skid register.
module xfcr_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  xfcr_pkg::result_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output xfcr_pkg::result_t data_o
);
  import xfcr_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    push, pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;
  assign push    = valid_i && ready_o;
  assign pop     = main_valid_q && ready_i;

  // Refill the result register from skid or input; park input in skid on stall
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = data_i;
        main_valid_d = push;
      end
    end else if (push) begin
      if (!main_valid_q) begin
        main_d       = data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule
